// ----- hdl/sdsf_pkg.sv -----
// shared types and constants for the scanline dirty span finder
// no dependencies; used by every module under hdl
`default_nettype none

package sdsf_pkg;

	localparam int MAX_WIDTH_DEF = 2048;
	localparam int ROW_W         = 10;
	localparam int GAP_W         = 8;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [GAP_W-1:0] GAP_RESET = 8'd4;

	// per-pixel classification made by the front end
	typedef struct packed {
		logic differs;
		logic row_end;
	} pix_class_t;

	localparam int CLASS_W = $bits(pix_class_t);

endpackage

`default_nettype wire

// ----- hdl/sdsf_front.sv -----
// front end: accepts pixel items, tracks the column and classifies each pixel
// depends on sdsf_pkg
`default_nettype none

module sdsf_front #(
	parameter int MAX_WIDTH = sdsf_pkg::MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [15:0]              new_pixel,
	input  wire logic [15:0]              old_pixel,
	input  wire logic                     last_in_row,
	input  wire logic                     q_full,
	output logic                          push,
	output sdsf_pkg::pix_class_t          cls,
	output logic [COL_W-1:0]              col
);

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(MAX_WIDTH - 1);

	logic [COL_W-1:0] column_q;

	assign in_stall    = q_full;
	assign push        = in_valid & ~q_full;
	assign col         = column_q;
	assign cls.differs = (new_pixel != old_pixel);
	// an overlong row ends at the last column regardless of the flag
	assign cls.row_end = last_in_row | (column_q == LAST_COL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
		end else if (push) begin
			if (cls.row_end) begin
				column_q <= '0;
			end else begin
				column_q <= column_q + COL_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/sdsf_queue.sv -----
// short register queue between front and back end
// depends on sdsf_pkg for its default depth
`default_nettype none

module sdsf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = sdsf_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              pop,
	output logic                   full,
	output logic                   not_empty,
	output logic [DATA_W-1:0]      rdata
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) full |-> !push || pop;
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("queue overflow");

	property p_no_underflow;
		@(posedge clk) disable iff (!arst_n) pop |-> not_empty;
	endproperty
	a_no_underflow: assert property (p_no_underflow) else $error("queue underflow");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(DEPTH);
	endproperty
	a_count_bound: assert property (p_count_bound) else $error("queue count out of range");

endmodule

`default_nettype wire

// ----- hdl/sdsf_back.sv -----
// back end: span state, gap register and output register
// depends on sdsf_pkg
`default_nettype none

module sdsf_back #(
	parameter int COL_W = 11,
	parameter int END_W = COL_W + 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         merge_gap_we,
	input  wire logic [sdsf_pkg::GAP_W-1:0]   merge_gap_wdata,
	input  wire logic                         q_not_empty,
	input  wire sdsf_pkg::pix_class_t         cls,
	input  wire logic [COL_W-1:0]             col,
	input  wire logic [sdsf_pkg::ROW_W-1:0]   row_in,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [sdsf_pkg::ROW_W-1:0]        span_row,
	output logic [COL_W-1:0]                  start_x,
	output logic [END_W-1:0]                  end_x,
	output logic [END_W-1:0]                  span_size
);

	logic [sdsf_pkg::GAP_W-1:0] gap_q;
	logic                       in_span_q;
	logic [COL_W-1:0]           open_start_q;
	logic [END_W-1:0]           open_end_q;
	logic [sdsf_pkg::GAP_W-1:0] quiet_q;

	logic                       out_valid_q;
	logic [sdsf_pkg::ROW_W-1:0] span_row_q;
	logic [COL_W-1:0]           start_x_q;
	logic [END_W-1:0]           end_x_q;
	logic [END_W-1:0]           span_size_q;

	logic                       in_nx;
	logic [COL_W-1:0]           start_nx;
	logic [END_W-1:0]           end_nx;
	logic [sdsf_pkg::GAP_W-1:0] quiet_nx;
	logic                       gap_close;
	logic                       emit;
	logic [END_W-1:0]           col_next;

	assign pop       = q_not_empty & (~out_valid_q | ~out_stall);
	assign col_next  = END_W'(col) + END_W'(1);

	always_comb begin
		in_nx     = in_span_q;
		start_nx  = open_start_q;
		end_nx    = open_end_q;
		quiet_nx  = quiet_q;
		gap_close = 1'b0;
		if (in_span_q) begin
			if (cls.differs) begin
				end_nx   = col_next;
				quiet_nx = '0;
			end else if (quiet_q >= gap_q) begin
				gap_close = 1'b1;
				in_nx     = 1'b0;
				quiet_nx  = '0;
			end else begin
				quiet_nx = quiet_q + sdsf_pkg::GAP_W'(1);
			end
		end else if (cls.differs) begin
			in_nx    = 1'b1;
			start_nx = col;
			end_nx   = col_next;
			quiet_nx = '0;
		end
		emit = gap_close | (cls.row_end & in_nx);
		if (cls.row_end && in_nx) begin
			in_nx    = 1'b0;
			quiet_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q        <= sdsf_pkg::GAP_RESET;
			in_span_q    <= 1'b0;
			open_start_q <= '0;
			open_end_q   <= '0;
			quiet_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (merge_gap_we) begin
				gap_q <= merge_gap_wdata;
			end
			if (pop) begin
				in_span_q    <= in_nx;
				open_start_q <= start_nx;
				open_end_q   <= end_nx;
				quiet_q      <= quiet_nx;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			span_row_q  <= row_in;
			start_x_q   <= start_nx;
			end_x_q     <= end_nx;
			span_size_q <= end_nx - END_W'(start_nx);
		end
	end

	assign out_valid = out_valid_q;
	assign span_row  = span_row_q;
	assign start_x   = start_x_q;
	assign end_x     = end_x_q;
	assign span_size = span_size_q;

	property p_span_bounds;
		@(posedge clk) disable iff (!arst_n)
			in_span_q |-> open_end_q > END_W'(open_start_q);
	endproperty
	a_span_bounds: assert property (p_span_bounds) else $error("open span has bad bounds");

	property p_row_end_closes;
		@(posedge clk) disable iff (!arst_n) pop && cls.row_end |=> !in_span_q;
	endproperty
	a_row_end_closes: assert property (p_row_end_closes) else $error("span open past row end");

	property p_no_emit_when_busy;
		@(posedge clk) disable iff (!arst_n) out_valid_q && out_stall |-> !pop;
	endproperty
	a_no_emit_when_busy: assert property (p_no_emit_when_busy)
		else $error("item taken while result held");

	property p_size_matches;
		@(posedge clk) disable iff (!arst_n)
			out_valid_q |-> span_size_q == end_x_q - END_W'(start_x_q);
	endproperty
	a_size_matches: assert property (p_size_matches) else $error("span size mismatch");

endmodule

`default_nettype wire

// ----- hdl/scanline_dirty_span_finder_core.sv -----
// scanline dirty span finder, top level: front end, queue, back end
// an accepted item is written into the queue; the span it closes is registered in the output register
// throughput: one item per cycle; the back end settles one pixel per cycle
// a held result stalls the back end, the four-entry queue absorbs the front end
// reset: arst_n clears column, span state, queue and output valid; merge_gap returns to 4
// depends on sdsf_pkg, sdsf_front, sdsf_queue, sdsf_back
`default_nettype none

module scanline_dirty_span_finder_core #(
	parameter int MAX_WIDTH = sdsf_pkg::MAX_WIDTH_DEF,
	parameter int COL_W     = $clog2(MAX_WIDTH),
	parameter int END_W     = COL_W + 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write, merge_gap only
	input  wire logic                        merge_gap_we,
	input  wire logic [sdsf_pkg::GAP_W-1:0]  merge_gap_wdata,
	// pixel items
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [15:0]                 new_pixel,
	input  wire logic [15:0]                 old_pixel,
	input  wire logic [sdsf_pkg::ROW_W-1:0]  row,
	input  wire logic                        last_in_row,
	// span items
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [sdsf_pkg::ROW_W-1:0]       span_row,
	output logic [COL_W-1:0]                 start_x,
	output logic [END_W-1:0]                 end_x,
	output logic [END_W-1:0]                 span_size
);

	// queue entry: class bits, column, row
	localparam int REC_W = sdsf_pkg::CLASS_W + COL_W + sdsf_pkg::ROW_W;

	logic                       q_full;
	logic                       q_not_empty;
	logic                       push;
	logic                       pop;
	sdsf_pkg::pix_class_t       f_cls;
	logic [COL_W-1:0]           f_col;
	logic [REC_W-1:0]           q_wdata;
	logic [REC_W-1:0]           q_rdata;
	sdsf_pkg::pix_class_t       b_cls;
	logic [COL_W-1:0]           b_col;
	logic [sdsf_pkg::ROW_W-1:0] b_row;

	// front end: column counter and pixel compare
	sdsf_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.COL_W     (COL_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.new_pixel   (new_pixel),
		.old_pixel   (old_pixel),
		.last_in_row (last_in_row),
		.q_full      (q_full),
		.push        (push),
		.cls         (f_cls),
		.col         (f_col)
	);

	assign q_wdata = {f_cls, f_col, row};

	// decouples pixel intake from span closing
	sdsf_queue #(
		.DATA_W (REC_W),
		.DEPTH  (sdsf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wdata     (q_wdata),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.rdata     (q_rdata)
	);

	assign {b_cls, b_col, b_row} = q_rdata;

	// back end: open span tracking, gap counting, result register
	sdsf_back #(
		.COL_W (COL_W),
		.END_W (END_W)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.merge_gap_we    (merge_gap_we),
		.merge_gap_wdata (merge_gap_wdata),
		.q_not_empty     (q_not_empty),
		.cls             (b_cls),
		.col             (b_col),
		.row_in          (b_row),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.span_row        (span_row),
		.start_x         (start_x),
		.end_x           (end_x),
		.span_size       (span_size)
	);

endmodule

`default_nettype wire
